// ===== rtl/hhcs_pkg.sv =====
`default_nettype none
package hhcs_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FWD  = 2'd1;
  localparam logic [1:0] OP_BACK = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB = 5'd28;
  localparam logic [5:0] LOAD_MIN_HALF = 6'd30;
  localparam logic [4:0] CUR_MIN_HALF = 5'd30;

  // divisibility by 25: y * inv(25) mod 2^16 lands at or below 65535/25
  localparam logic [15:0] INV25 = 16'h5C29;
  localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic        half;
  } cal_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } item_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = DAYS_FEB;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hhcs_days.sv =====
`default_nettype none
module hhcs_days (
  input  wire logic [15:0] year,
  input  wire logic [3:0]  month,
  output logic [4:0]       dim
);

  logic [15:0] prod;
  logic        div25;
  logic        leap;

  // only the low 16 bits of the product matter for the divisibility test
  assign prod  = year * hhcs_pkg::INV25;
  assign div25 = (prod <= hhcs_pkg::DIV25_MAX);
  // div by 4, and if a century then div by 400 (div16 & div25)
  assign leap  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));

  always_comb begin
    if (month == hhcs_pkg::MONTH_FEB) begin
      dim = leap ? hhcs_pkg::DAYS_FEB_LEAP : hhcs_pkg::DAYS_FEB;
    end else begin
      dim = hhcs_pkg::month_len(month);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hhcs_next.sv =====
`default_nettype none
module hhcs_next (
  input  wire hhcs_pkg::cal_t  cur,
  input  wire hhcs_pkg::item_t item,
  output hhcs_pkg::cal_t       nxt,
  output logic                 err
);

  logic [15:0] dim_year;
  logic [3:0]  dim_month;
  logic [4:0]  dim;
  logic [3:0]  back_month;
  logic        load_ok;

  // month that precedes the current one; January wraps to December
  assign back_month = (cur.month > hhcs_pkg::MONTH_JAN) ? cur.month - 4'd1
                                                        : hhcs_pkg::MONTH_DEC;

  always_comb begin
    case (item.op)
      hhcs_pkg::OP_LOAD: begin
        dim_year  = item.year;
        dim_month = item.month;
      end
      hhcs_pkg::OP_BACK: begin
        dim_year  = cur.year;
        dim_month = back_month;
      end
      default: begin
        dim_year  = cur.year;
        dim_month = cur.month;
      end
    endcase
  end

  hhcs_days u_days (
    .year  (dim_year),
    .month (dim_month),
    .dim   (dim)
  );

  assign load_ok = (item.month inside {[hhcs_pkg::MONTH_JAN:hhcs_pkg::MONTH_DEC]})
                && (item.day >= hhcs_pkg::DAY_FIRST) && (item.day <= dim)
                && (item.hour <= hhcs_pkg::HOUR_LAST)
                && ((item.minute == 6'd0) || (item.minute == hhcs_pkg::LOAD_MIN_HALF));

  always_comb begin
    nxt = cur;
    err = 1'b0;
    case (item.op)
      hhcs_pkg::OP_LOAD: begin
        if (load_ok) begin
          nxt.year  = item.year;
          nxt.month = item.month;
          nxt.day   = item.day;
          nxt.hour  = item.hour;
          nxt.half  = (item.minute == hhcs_pkg::LOAD_MIN_HALF);
        end else begin
          err = 1'b1;
        end
      end
      hhcs_pkg::OP_FWD: begin
        nxt.half = ~cur.half;
        if (cur.half) begin
          if (cur.hour < hhcs_pkg::HOUR_LAST) begin
            nxt.hour = cur.hour + 5'd1;
          end else begin
            nxt.hour = 5'd0;
            if (cur.day < dim) begin
              nxt.day = cur.day + 5'd1;
            end else begin
              nxt.day = hhcs_pkg::DAY_FIRST;
              if (cur.month < hhcs_pkg::MONTH_DEC) begin
                nxt.month = cur.month + 4'd1;
              end else begin
                nxt.month = hhcs_pkg::MONTH_JAN;
                nxt.year  = cur.year + 16'd1;
              end
            end
          end
        end
      end
      hhcs_pkg::OP_BACK: begin
        nxt.half = ~cur.half;
        if (!cur.half) begin
          if (cur.hour > 5'd0) begin
            nxt.hour = cur.hour - 5'd1;
          end else begin
            nxt.hour = hhcs_pkg::HOUR_LAST;
            if (cur.day > hhcs_pkg::DAY_FIRST) begin
              nxt.day = cur.day - 5'd1;
            end else begin
              nxt.month = back_month;
              nxt.day   = dim;
              if (cur.month == hhcs_pkg::MONTH_JAN) begin
                nxt.year = cur.year - 16'd1;
              end
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/half_hour_calendar_stepper.sv =====
// Half-hour calendar stepper.
// Input channel (in_valid / in_stall): op selects load (checked date and
// time), step forward one half hour, step back one half hour, or (any other
// op) no change. Load fields are ignored on steps.
// Result channel (out_valid / out_stall): the date and time after each
// transaction, plus load_error for a rejected load (state left as it was).
// Path: the accepting edge loads the input register; once the item
// advances, the result register (which also holds the calendar state)
// takes the new value and out_valid rises.
// Throughput: one transaction per cycle while out_stall is low; the next-state logic reads the
// state register directly, so back-to-back items chain through it.
// Reset (rst_n low, synchronous): state becomes 1 January year 1, 00:00,
// both valid flags clear.
// Stall: while out_stall holds a pending result, the state does not advance;
// one further transaction waits in the input register, after which
// in_stall rises.
`default_nettype none
module half_hour_calendar_stepper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [4:0]  in_load_hour,
  input  wire logic [5:0]  in_load_minute,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cur_year,
  output logic [3:0]       out_cur_month,
  output logic [4:0]       out_cur_day,
  output logic [4:0]       out_cur_hour,
  output logic [4:0]       out_cur_minute,
  output logic             out_load_error
);

  hhcs_pkg::item_t item_r;
  logic            item_vld_r;
  hhcs_pkg::cal_t  cal_r;
  hhcs_pkg::cal_t  cal_nxt;
  logic            err_r;
  logic            err_nxt;
  logic            out_vld_r;
  logic            advance;

  // item moves into the result stage when that stage is empty or drains
  assign advance  = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && out_vld_r && out_stall;

  hhcs_next u_next (
    .cur  (cal_r),
    .item (item_r),
    .nxt  (cal_nxt),
    .err  (err_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{op: in_op, year: in_load_year, month: in_load_month,
                  day: in_load_day, hour: in_load_hour, minute: in_load_minute};
    end
    if (advance) begin
      err_r <= err_nxt;
    end
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cal_r      <= '{year: 16'd1, month: hhcs_pkg::MONTH_JAN,
                      day: hhcs_pkg::DAY_FIRST, hour: 5'd0, half: 1'b0};
    end else begin
      if (!in_stall) begin
        item_vld_r <= in_valid;
      end
      if (advance) begin
        cal_r     <= cal_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_cur_year   = cal_r.year;
  assign out_cur_month  = cal_r.month;
  assign out_cur_day    = cal_r.day;
  assign out_cur_hour   = cal_r.hour;
  assign out_cur_minute = cal_r.half ? hhcs_pkg::CUR_MIN_HALF : 5'd0;
  assign out_load_error = err_r;

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (cal_r.month >= hhcs_pkg::MONTH_JAN) &&
                  (cal_r.month <= hhcs_pkg::MONTH_DEC) &&
                  (cal_r.day >= hhcs_pkg::DAY_FIRST) &&
                  (cal_r.hour <= hhcs_pkg::HOUR_LAST))
    else $error("calendar state out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_vld_r && out_vld_r)
    else $error("input stalled without a pending result");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && err_nxt) |=> (cal_r == $past(cal_r)) && err_r)
    else $error("rejected load changed the state");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> (cal_r == $past(cal_r)))
    else $error("state moved without a transaction");

endmodule
`default_nettype wire

// ===== bench/tb_half_hour_calendar_stepper.sv =====
`timescale 1ns / 1ps
module tb_half_hour_calendar_stepper;
  import hhcs_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 285;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [4:0]  minute;
    logic        err;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_NOP;
  logic [15:0] in_load_year = '0;
  logic [3:0]  in_load_month = '0;
  logic [4:0]  in_load_day = '0;
  logic [4:0]  in_load_hour = '0;
  logic [5:0]  in_load_minute = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_cur_year;
  logic [3:0]  out_cur_month;
  logic [4:0]  out_cur_day;
  logic [4:0]  out_cur_hour;
  logic [4:0]  out_cur_minute;
  logic        out_load_error;

  item_t    calendar_cmds[$];
  reading_t expected_dates[$];
  cal_t     model_cal;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       in_took = 1'b0;

  half_hour_calendar_stepper DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .in_load_hour   (in_load_hour),
    .in_load_minute (in_load_minute),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cur_year   (out_cur_year),
    .out_cur_month  (out_cur_month),
    .out_cur_day    (out_cur_day),
    .out_cur_hour   (out_cur_hour),
    .out_cur_minute (out_cur_minute),
    .out_load_error (out_load_error)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap(logic [15:0] y);
    int unsigned v;
    v = y;
    if (v % 100 == 0) return (v % 400 == 0);
    return (v % 4 == 0);
  endfunction

  function automatic logic [4:0] days_of(logic [15:0] y, logic [3:0] m);
    case (m)
      MONTH_FEB:                      return is_leap(y) ? DAYS_FEB_LEAP : DAYS_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:        return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                   return 5'd31;
      default:                        return 5'd0;
    endcase
  endfunction

  // applies one transaction to the model calendar, returns the expected reading
  function automatic reading_t advance_calendar(item_t c);
    reading_t r;
    bit ok;
    r.err = 1'b0;
    case (c.op)
      OP_LOAD: begin
        ok = c.month >= MONTH_JAN && c.month <= MONTH_DEC && c.day >= DAY_FIRST &&
             c.day <= days_of(c.year, c.month) && c.hour <= HOUR_LAST &&
             (c.minute == 6'd0 || c.minute == LOAD_MIN_HALF);
        if (ok) begin
          model_cal.year  = c.year;
          model_cal.month = c.month;
          model_cal.day   = c.day;
          model_cal.hour  = c.hour;
          model_cal.half  = (c.minute == LOAD_MIN_HALF);
        end else begin
          r.err = 1'b1;
        end
      end
      OP_FWD: begin
        if (!model_cal.half) begin
          model_cal.half = 1'b1;
        end else begin
          model_cal.half = 1'b0;
          if (model_cal.hour < HOUR_LAST) begin
            model_cal.hour++;
          end else begin
            model_cal.hour = 5'd0;
            if (model_cal.day < days_of(model_cal.year, model_cal.month)) begin
              model_cal.day++;
            end else begin
              model_cal.day = DAY_FIRST;
              if (model_cal.month < MONTH_DEC) begin
                model_cal.month++;
              end else begin
                model_cal.month = MONTH_JAN;
                model_cal.year = model_cal.year + 16'd1;
              end
            end
          end
        end
      end
      OP_BACK: begin
        if (model_cal.half) begin
          model_cal.half = 1'b0;
        end else begin
          model_cal.half = 1'b1;
          if (model_cal.hour > 5'd0) begin
            model_cal.hour--;
          end else begin
            model_cal.hour = HOUR_LAST;
            if (model_cal.day > DAY_FIRST) begin
              model_cal.day--;
            end else begin
              if (model_cal.month > MONTH_JAN) begin
                model_cal.month--;
              end else begin
                model_cal.month = MONTH_DEC;
                model_cal.year = model_cal.year - 16'd1;
              end
              model_cal.day = days_of(model_cal.year, model_cal.month);
            end
          end
        end
      end
      default: ;
    endcase
    r.year   = model_cal.year;
    r.month  = model_cal.month;
    r.day    = model_cal.day;
    r.hour   = model_cal.hour;
    r.minute = model_cal.half ? CUR_MIN_HALF : 5'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic item_t make_cmd(logic [1:0] op, logic [15:0] y, logic [3:0] m,
                                     logic [4:0] d, logic [4:0] h, logic [5:0] mi);
    item_t c;
    c.op = op;
    c.year = y;
    c.month = m;
    c.day = d;
    c.hour = h;
    c.minute = mi;
    return c;
  endfunction

  // step, no-op or load with junk in the load fields
  function automatic item_t junk_cmd(logic [1:0] op);
    return make_cmd(op, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                    6'($urandom));
  endfunction

  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 163) * 400);
      3:       return 16'($urandom_range(0, 655) * 100);
      4:       return 16'($urandom_range(0, 16383) * 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // valid load, often at a month rollover, then a run of steps, mostly in one direction
  task automatic queue_rollover_run();
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  h;
    logic [1:0]  dir;
    logic [1:0]  other;
    int          kind;
    kind = $urandom_range(0, 2);
    y = pick_year();
    case ($urandom_range(0, 3))
      0:       m = (kind == 1) ? MONTH_JAN : MONTH_DEC;
      1:       m = MONTH_FEB;
      default: m = 4'($urandom_range(1, 12));
    endcase
    case (kind)
      0: begin
        d = days_of(y, m);
        h = HOUR_LAST;
        dir = OP_FWD;
      end
      1: begin
        d = DAY_FIRST;
        h = 5'd0;
        dir = OP_BACK;
      end
      default: begin
        d = 5'($urandom_range(1, days_of(y, m)));
        h = 5'($urandom_range(0, 23));
        dir = $urandom_range(0, 1) ? OP_FWD : OP_BACK;
      end
    endcase
    other = (dir == OP_FWD) ? OP_BACK : OP_FWD;
    calendar_cmds.push_back(make_cmd(OP_LOAD, y, m, d, h,
                                     $urandom_range(0, 1) ? LOAD_MIN_HALF : 6'd0));
    repeat ($urandom_range(1, 6))
      calendar_cmds.push_back(junk_cmd(($urandom_range(0, 99) < 80) ? dir : other));
  endtask

  task automatic queue_random_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      queue_rollover_run();
    end else if (r < 87) begin
      calendar_cmds.push_back(junk_cmd(OP_LOAD));
    end else if (r < 93) begin
      calendar_cmds.push_back(junk_cmd(OP_NOP));
    end else begin
      repeat ($urandom_range(1, 4))
        calendar_cmds.push_back(junk_cmd($urandom_range(0, 1) ? OP_FWD : OP_BACK));
    end
  endtask

  task automatic run_phase(input int idle, input int stall);
    int target;
    send_idle_pct = idle;
    stall_pct = stall;
    target = calendar_cmds.size() + PHASE_ITEMS;
    while (calendar_cmds.size() < target) queue_random_burst();
    while (calendar_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic queue_directed();
    calendar_cmds.push_back(junk_cmd(OP_FWD));
    calendar_cmds.push_back(junk_cmd(OP_BACK));
    // back across 1 Jan year 1 00:00 into year 0
    calendar_cmds.push_back(junk_cmd(OP_BACK));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd0, MONTH_FEB, 5'd29, HOUR_LAST,
                                     LOAD_MIN_HALF));
    calendar_cmds.push_back(junk_cmd(OP_FWD));
    calendar_cmds.push_back(junk_cmd(OP_BACK));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'hFFFF, MONTH_DEC, 5'd31, HOUR_LAST,
                                     LOAD_MIN_HALF));
    calendar_cmds.push_back(junk_cmd(OP_FWD));
    calendar_cmds.push_back(junk_cmd(OP_BACK));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd1900, MONTH_FEB, 5'd29, 5'd0, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2000, MONTH_FEB, 5'd29, 5'd0, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2023, MONTH_FEB, 5'd29, 5'd0, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2100, 4'd3, DAY_FIRST, 5'd0, 6'd0));
    calendar_cmds.push_back(junk_cmd(OP_BACK));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd0, 5'd10, 5'd5, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd13, 5'd10, 5'd5, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'hFFFF, 4'hF, 5'd31, 5'd31, 6'd63));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd5, 5'd0, 5'd5, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd4, 5'd31, 5'd5, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd4, 5'd30, 5'd24, 6'd0));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd4, 5'd30, 5'd5, 6'd1));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, 4'd4, 5'd30, 5'd5, 6'd63));
    calendar_cmds.push_back(make_cmd(OP_NOP, 16'hFFFF, 4'hF, 5'd31, 5'd31, 6'd63));
    calendar_cmds.push_back(make_cmd(OP_LOAD, 16'd2024, MONTH_DEC, 5'd31, HOUR_LAST,
                                     LOAD_MIN_HALF));
    calendar_cmds.push_back(junk_cmd(OP_FWD));
  endtask

  // driver: present a new transaction once the current one has gone in
  always @(negedge clk) begin
    item_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (calendar_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = calendar_cmds.pop_front();
        in_op          <= nxt.op;
        in_load_year   <= nxt.year;
        in_load_month  <= nxt.month;
        in_load_day    <= nxt.day;
        in_load_hour   <= nxt.hour;
        in_load_minute <= nxt.minute;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: check delivered results, predict accepted transactions
  always @(posedge clk) begin
    reading_t want;
    item_t    got_cmd;
    if (!rst_n) begin
      model_cal = '{year: 16'd1, month: MONTH_JAN, day: DAY_FIRST, hour: 5'd0, half: 1'b0};
      expected_dates.delete();
      in_took = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with nothing expected, year", out_cur_year, -1);
        end else begin
          want = expected_dates.pop_front();
          if (out_cur_year !== want.year)
            report_mismatch("cur_year", out_cur_year, want.year);
          if (out_cur_month !== want.month)
            report_mismatch("cur_month", out_cur_month, want.month);
          if (out_cur_day !== want.day)
            report_mismatch("cur_day", out_cur_day, want.day);
          if (out_cur_hour !== want.hour)
            report_mismatch("cur_hour", out_cur_hour, want.hour);
          if (out_cur_minute !== want.minute)
            report_mismatch("cur_minute", out_cur_minute, want.minute);
          if (out_load_error !== want.err)
            report_mismatch("load_error", out_load_error, want.err);
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        got_cmd = make_cmd(in_op, in_load_year, in_load_month, in_load_day, in_load_hour,
                           in_load_minute);
        expected_dates.push_back(advance_calendar(got_cmd));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    queue_directed();
    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(24, 24);
    while (calendar_cmds.size() != 0 || in_valid || expected_dates.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_dates.size() != 0)
      report_mismatch("results never delivered", expected_dates.size(), 0);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== half_hour_calendar_stepper.f =====
rtl/hhcs_pkg.sv
rtl/hhcs_days.sv
rtl/hhcs_next.sv
rtl/half_hour_calendar_stepper.sv
bench/tb_half_hour_calendar_stepper.sv
